// ===== hdl/cscr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cscr_pkg
// Field widths and command codes shared by the shard command router.
// ----------------------------------------------------------------------------
package cscr_pkg;

   // input field widths
   localparam int OPC_W  = 3;
   localparam int KEY_W  = 32;
   localparam int OFF_W  = 11;
   localparam int TID_W  = 32;
   localparam int SLOT_W = 4;
   localparam int BEAT_W = 64;

   // result field widths
   localparam int PAY_W  = 64;
   localparam int MASK_W = 16;

   // command codes; the remaining codes are treated as nop
   typedef enum logic [OPC_W-1:0] {
      OP_NOP    = 3'd0,
      OP_BULK   = 3'd1,
      OP_WRITE  = 3'd2,
      OP_SEARCH = 3'd3,
      OP_ROUTE  = 3'd4
   } opcode_type;

endpackage : cscr_pkg
`default_nettype wire

// ===== hdl/cam_shard_command_router.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cam_shard_command_router
// Routes write, search and bulk-load commands to a bank of lookup blocks
// through a route table that maps each block to a table id.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  opcode, key, offset, table id,
//                                              route slot, beat data
//  rsp_      out        rsp_valid / rsp_ready  payload, dest_mask, miss, last
//
//  An input register takes one transaction per cycle while req_ready is high;
//  the decode, route table compare and mask build sit between it and a result
//  register. Bulk beats and bulk headers give one result; write one and
//  search one give two results and hold the result register until both
//  are taken. Route entry and nop leave with no result.
//  Reset clears the route table, bulk state and both valid flags at once.
//  A stall on rsp_ready holds the result register, then the input register,
//  then drops req_ready.
// ----------------------------------------------------------------------------
module cam_shard_command_router #(
   parameter int BLOCKS          = 16,
   parameter int BLOCK_ENTRIES   = 128,
   parameter int BEATS_PER_BLOCK = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // command input
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [cscr_pkg::OPC_W-1:0]  req_opcode,
   input  wire logic [cscr_pkg::KEY_W-1:0]  req_key_value,
   input  wire logic [cscr_pkg::OFF_W-1:0]  req_entry_offset,
   input  wire logic [cscr_pkg::TID_W-1:0]  req_tbl_tag,
   input  wire logic [cscr_pkg::SLOT_W-1:0] req_route_slot,
   input  wire logic [cscr_pkg::BEAT_W-1:0] req_beat_data,
   // packet output
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [cscr_pkg::PAY_W-1:0]       rsp_payload,
   output logic [cscr_pkg::MASK_W-1:0]      rsp_dest_mask,
   output logic                             rsp_miss,
   output logic                             rsp_last
);

   import cscr_pkg::*;

   localparam int BLK_W    = $clog2(BLOCKS);
   localparam int SUB_W    = (BEATS_PER_BLOCK > 1) ? $clog2(BEATS_PER_BLOCK) : 1;
   localparam int PAD_W    = (BLOCKS > MASK_W) ? BLOCKS : MASK_W;
   localparam int SUM_W    = OFF_W + 1;
   // offset / BLOCK_ENTRIES by reciprocal, exact for every 11-bit offset
   localparam int ENT_LOG  = $clog2(BLOCK_ENTRIES);
   localparam int DIV_SH   = OFF_W + ENT_LOG;
   localparam int MULT_W   = OFF_W + 2;
   localparam int PROD_W   = OFF_W + MULT_W;
   localparam int DIV_MULT = ((1 << DIV_SH) + BLOCK_ENTRIES - 1) / BLOCK_ENTRIES;
   localparam int BACK_W   = OFF_W + ENT_LOG + 1;

   localparam logic [MULT_W-1:0] DIV_MULT_C = MULT_W'(DIV_MULT);
   localparam logic [BACK_W-1:0] ENTRIES_C  = BACK_W'(BLOCK_ENTRIES);
   localparam logic [PAD_W-1:0]  ALL_PAD    = PAD_W'({BLOCKS{1'b1}});
   localparam logic [SUB_W-1:0]  SUB_LAST   = SUB_W'(BEATS_PER_BLOCK - 1);
   localparam logic [BLK_W-1:0]  BLK_LAST   = BLK_W'(BLOCKS - 1);
   localparam logic [SUM_W-1:0]  BLOCKS_C   = SUM_W'(BLOCKS);

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [OPC_W-1:0]    in_op_ff;
   logic [KEY_W-1:0]    in_key_ff;
   logic [OFF_W-1:0]    in_offset_ff;
   logic [OFF_W-1:0]    in_quot_ff, in_quot_in;
   logic [TID_W-1:0]    in_tid_ff;
   logic [SLOT_W-1:0]   in_slot_ff;
   logic [BEAT_W-1:0]   in_beat_ff;

   // route table and bulk-load state
   logic [TID_W-1:0]    route_ff [BLOCKS];
   logic                bulk_ff, bulk_in;
   logic [BLK_W-1:0]    blk_cnt_ff, blk_cnt_in;
   logic [SUB_W-1:0]    sub_cnt_ff, sub_cnt_in;

   // result register: up to two results left
   logic [1:0]          res_cnt_ff, res_cnt_in;
   logic [PAY_W-1:0]    res_p0_ff, res_p0_in;
   logic [PAY_W-1:0]    res_p1_ff, res_p1_in;
   logic [MASK_W-1:0]   res_mask_ff, res_mask_in;
   logic                res_miss_ff, res_miss_in;

   logic [PROD_W-1:0]   div_prod;
   logic [BACK_W-1:0]   back_prod;
   logic [OFF_W-1:0]    rem;
   logic [BLOCKS-1:0]   hit;
   logic                any_hit;
   logic [BLK_W-1:0]    first_blk;
   logic [SUM_W-1:0]    target;
   logic                wr_ok;
   logic [PAD_W-1:0]    wr_pad, search_pad, beat_pad;
   logic [PAY_W-1:0]    wr_word;
   logic                has_res, res_free, move, rsp_fire;

   // quotient of the offset, taken at the input port
   assign div_prod   = PROD_W'(req_entry_offset) * PROD_W'(DIV_MULT_C);
   assign in_quot_in = OFF_W'(div_prod >> DIV_SH);

   // remainder from the registered quotient
   assign back_prod = BACK_W'(in_quot_ff) * ENTRIES_C;
   assign rem       = in_offset_ff - back_prod[OFF_W-1:0];
   assign wr_word   = {{(PAY_W-KEY_W-OFF_W){1'b0}}, rem, in_key_ff};

   // route table compare and first match
   always_comb begin
      for (int i = 0; i < BLOCKS; i++) begin
         hit[i] = (route_ff[i] == in_tid_ff);
      end
      any_hit   = |hit;
      first_blk = '0;
      for (int i = BLOCKS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            first_blk = BLK_W'(i);
         end
      end
   end

   // destination masks
   assign target     = SUM_W'(first_blk) + SUM_W'(in_quot_ff);
   assign wr_ok      = any_hit && (target < BLOCKS_C);
   assign wr_pad     = wr_ok ? (PAD_W'(1) << target) : '0;
   assign search_pad = PAD_W'(hit);
   assign beat_pad   = PAD_W'(1) << blk_cnt_ff;

   // handshake between the two registers
   always_comb begin
      has_res  = bulk_ff || (in_op_ff inside {OP_BULK, OP_WRITE, OP_SEARCH});
      res_free = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_ready);
      move     = in_valid_ff && (!has_res || res_free);
      rsp_fire = rsp_valid && rsp_ready;
   end

   assign req_ready   = !in_valid_ff || move;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (move ? 1'b0 : in_valid_ff);

   // result build
   always_comb begin
      res_cnt_in  = rsp_fire ? (res_cnt_ff - 2'd1) : res_cnt_ff;
      res_p0_in   = res_p0_ff;
      res_p1_in   = res_p1_ff;
      res_mask_in = res_mask_ff;
      res_miss_in = res_miss_ff;
      if (move && has_res) begin
         res_p0_in   = '0;
         res_miss_in = 1'b0;
         if (bulk_ff) begin
            res_p1_in   = in_beat_ff;
            res_mask_in = beat_pad[MASK_W-1:0];
            res_cnt_in  = 2'd1;
         end else begin
            case (opcode_type'(in_op_ff))
               OP_BULK: begin
                  res_p1_in   = PAY_W'(OP_BULK);
                  res_mask_in = ALL_PAD[MASK_W-1:0];
                  res_cnt_in  = 2'd1;
               end
               OP_WRITE: begin
                  res_p0_in   = PAY_W'(OP_WRITE);
                  res_p1_in   = wr_word;
                  res_mask_in = wr_pad[MASK_W-1:0];
                  res_miss_in = !wr_ok;
                  res_cnt_in  = 2'd2;
               end
               OP_SEARCH: begin
                  res_p0_in   = PAY_W'(OP_SEARCH);
                  res_p1_in   = PAY_W'(in_key_ff);
                  res_mask_in = search_pad[MASK_W-1:0];
                  res_cnt_in  = 2'd2;
               end
               default: begin
                  res_cnt_in = 2'd0;
               end
            endcase
         end
      end
   end

   // bulk-load beat counters
   always_comb begin
      bulk_in    = bulk_ff;
      blk_cnt_in = blk_cnt_ff;
      sub_cnt_in = sub_cnt_ff;
      if (move) begin
         if (bulk_ff) begin
            if (sub_cnt_ff == SUB_LAST) begin
               sub_cnt_in = '0;
               if (blk_cnt_ff == BLK_LAST) begin
                  bulk_in    = 1'b0;
                  blk_cnt_in = '0;
               end else begin
                  blk_cnt_in = blk_cnt_ff + BLK_W'(1);
               end
            end else begin
               sub_cnt_in = sub_cnt_ff + SUB_W'(1);
            end
         end else if (in_op_ff == OP_BULK) begin
            bulk_in    = 1'b1;
            blk_cnt_in = '0;
            sub_cnt_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         bulk_ff     <= 1'b0;
         blk_cnt_ff  <= '0;
         sub_cnt_ff  <= '0;
         res_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         bulk_ff     <= bulk_in;
         blk_cnt_ff  <= blk_cnt_in;
         sub_cnt_ff  <= sub_cnt_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   // route table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOCKS; i++) begin
            route_ff[i] <= '0;
         end
      end else if (move && !bulk_ff && (in_op_ff == OP_ROUTE)) begin
         for (int i = 0; i < BLOCKS; i++) begin
            if (int'(in_slot_ff) == i) begin
               route_ff[i] <= in_tid_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff     <= req_opcode;
         in_key_ff    <= req_key_value;
         in_offset_ff <= req_entry_offset;
         in_quot_ff   <= in_quot_in;
         in_tid_ff    <= req_tbl_tag;
         in_slot_ff   <= req_route_slot;
         in_beat_ff   <= req_beat_data;
      end
      res_p0_ff   <= res_p0_in;
      res_p1_ff   <= res_p1_in;
      res_mask_ff <= res_mask_in;
      res_miss_ff <= res_miss_in;
   end

   // result channel
   assign rsp_valid     = (res_cnt_ff != 2'd0);
   assign rsp_payload   = (res_cnt_ff == 2'd2) ? res_p0_ff : res_p1_ff;
   assign rsp_dest_mask = res_mask_ff;
   assign rsp_miss      = res_miss_ff;
   assign rsp_last      = (res_cnt_ff == 2'd1);

   // a missed write reaches no block
   a_miss_no_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_miss |-> rsp_dest_mask == '0)
      else $error("miss result with a nonzero destination mask");

   // the second word of a pair follows right after the header
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last)
      else $error("header taken without its data word behind it");

   // beat counters rest at zero outside a bulk load
   a_bulk_idle: assert property (@(posedge clock) disable iff (reset)
      !bulk_ff |-> (blk_cnt_ff == '0) && (sub_cnt_ff == '0))
      else $error("beat counters moved outside a bulk load");

endmodule : cam_shard_command_router
`default_nettype wire
